### rtl/iocd_pkg.sv
// Package for the impulse onset / clip / decay detector.
// Holds the payload and configuration types, register indexes and widths.
// No dependencies; every RTL file of the block refers to it by scoped names.
package iocd_pkg;

  // Raw words carry six padding bits below the level.
  localparam int unsigned SAMPLE_SHIFT = 6;
  localparam int unsigned RAW_W        = 32;
  localparam int unsigned LEVEL_W      = RAW_W - SAMPLE_SHIFT;
  localparam int unsigned RUN_W        = 10;
  localparam int unsigned RUN_CNT_W    = RUN_W + 1;
  localparam int unsigned WINDOW_W     = 12;
  localparam int unsigned DECAY_CNT_W  = WINDOW_W + 1;
  localparam int unsigned CFG_DATA_W   = LEVEL_W;
  localparam int unsigned CFG_IDX_W    = 3;

  // Register indexes on the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ONSET_JUMP   = 3'd0,
    REG_CLIP_LEVEL   = 3'd1,
    REG_MIN_CLIP_RUN = 3'd2,
    REG_MAX_CLIP_RUN = 3'd3,
    REG_DECAY_LEVEL  = 3'd4,
    REG_DECAY_LIMIT  = 3'd5
  } reg_idx_t;

  // Detector stage codes as reported on the result channel.
  typedef enum logic [1:0] {
    STAGE_SEEK  = 2'd0,
    STAGE_CLIP  = 2'd1,
    STAGE_DECAY = 2'd2,
    STAGE_HOLD  = 2'd3
  } stage_t;

  typedef struct packed {
    logic signed [RAW_W-1:0] raw_sample;
    logic                    buffer_start;
  } in_item_t;

  typedef struct packed {
    logic       event_found;
    logic [1:0] detector_stage;
  } out_item_t;

  typedef struct packed {
    logic        [LEVEL_W-1:0]  onset_jump;
    logic signed [LEVEL_W-1:0]  clip_level;
    logic        [RUN_W-1:0]    min_clip_run;
    logic        [RUN_W-1:0]    max_clip_run;
    logic signed [LEVEL_W-1:0]  decay_level;
    logic        [WINDOW_W-1:0] decay_limit;
  } cfg_t;

endpackage

### rtl/iocd_cfg_regs.sv
// Configuration register file of the detector.
// Depends on iocd_pkg for the register indexes and the cfg_t bundle.
module iocd_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [iocd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [iocd_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output iocd_pkg::cfg_t                   cfg
);

  iocd_pkg::cfg_t cfg_r;

  // Each register takes the low bits of the write data; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.onset_jump   <= iocd_pkg::LEVEL_W'(150000);
      cfg_r.clip_level   <= iocd_pkg::LEVEL_W'(131000);
      cfg_r.min_clip_run <= iocd_pkg::RUN_W'(2);
      cfg_r.max_clip_run <= iocd_pkg::RUN_W'(64);
      cfg_r.decay_level  <= iocd_pkg::LEVEL_W'(30000);
      cfg_r.decay_limit  <= iocd_pkg::WINDOW_W'(256);
    end else if (cfg_we) begin
      case (iocd_pkg::reg_idx_t'(cfg_index))
        iocd_pkg::REG_ONSET_JUMP:   cfg_r.onset_jump   <= cfg_wdata;
        iocd_pkg::REG_CLIP_LEVEL:   cfg_r.clip_level   <= cfg_wdata;
        iocd_pkg::REG_MIN_CLIP_RUN: cfg_r.min_clip_run <= cfg_wdata[iocd_pkg::RUN_W-1:0];
        iocd_pkg::REG_MAX_CLIP_RUN: cfg_r.max_clip_run <= cfg_wdata[iocd_pkg::RUN_W-1:0];
        iocd_pkg::REG_DECAY_LEVEL:  cfg_r.decay_level  <= cfg_wdata;
        iocd_pkg::REG_DECAY_LIMIT:  cfg_r.decay_limit  <= cfg_wdata[iocd_pkg::WINDOW_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

### rtl/iocd_core.sv
// Detector state and the per-word update logic.
// Depends on iocd_pkg for the payload, configuration and stage types.
module iocd_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                advance,
  input  iocd_pkg::in_item_t  item,
  input  iocd_pkg::cfg_t      cfg,
  output iocd_pkg::out_item_t result
);

  logic signed [iocd_pkg::LEVEL_W-1:0]     prev_level_r, prev_level_nxt;
  logic                                    onset_seen_r, onset_seen_nxt;
  logic                                    clip_conf_r, clip_conf_nxt;
  logic                                    found_hold_r, found_hold_nxt;
  logic [iocd_pkg::RUN_CNT_W-1:0]          run_cnt_r, run_cnt_nxt;
  logic [iocd_pkg::DECAY_CNT_W-1:0]        decay_cnt_r, decay_cnt_nxt;

  logic signed [iocd_pkg::LEVEL_W-1:0]     level;
  logic signed [iocd_pkg::LEVEL_W-1:0]     prev_base;
  logic signed [iocd_pkg::LEVEL_W+1:0]     rise;
  logic signed [iocd_pkg::LEVEL_W+1:0]     jump_min;
  logic                                    clipped;
  logic                                    restart;
  logic                                    event_hit;
  iocd_pkg::stage_t                        stage;

  // Level of the word, and its compares against the thresholds.
  // A buffer start makes the onset compare against level zero.
  assign level     = item.raw_sample[iocd_pkg::RAW_W-1:iocd_pkg::SAMPLE_SHIFT];
  assign prev_base = item.buffer_start ? '0 : prev_level_r;
  assign rise      = (iocd_pkg::LEVEL_W+2)'(level) - (iocd_pkg::LEVEL_W+2)'(prev_base);
  assign jump_min  = $signed({2'b00, cfg.onset_jump});
  assign clipped   = level >= cfg.clip_level;

  // Next state: a buffer start clears everything before the word is judged.
  always_comb begin
    prev_level_nxt = prev_level_r;
    onset_seen_nxt = onset_seen_r;
    clip_conf_nxt  = clip_conf_r;
    found_hold_nxt = found_hold_r;
    run_cnt_nxt    = run_cnt_r;
    decay_cnt_nxt  = decay_cnt_r;
    restart        = 1'b0;
    event_hit      = 1'b0;
    if (item.buffer_start) begin
      prev_level_nxt = '0;
      onset_seen_nxt = 1'b0;
      clip_conf_nxt  = 1'b0;
      found_hold_nxt = 1'b0;
      run_cnt_nxt    = '0;
      decay_cnt_nxt  = '0;
    end
    if (!found_hold_nxt) begin
      if (!onset_seen_nxt) begin
        // The rise is taken against the level held before this word.
        if (rise > jump_min && clipped) begin
          onset_seen_nxt = 1'b1;
        end
        prev_level_nxt = level;
      end else if (!clip_conf_nxt) begin
        if (clipped) begin
          run_cnt_nxt = run_cnt_nxt + 1'b1;
          if (run_cnt_nxt > iocd_pkg::RUN_CNT_W'(cfg.max_clip_run)) begin
            restart = 1'b1;
          end
        end else if (run_cnt_nxt < iocd_pkg::RUN_CNT_W'(cfg.min_clip_run)) begin
          restart = 1'b1;
        end else begin
          clip_conf_nxt = 1'b1;
        end
      end else begin
        decay_cnt_nxt = decay_cnt_nxt + 1'b1;
        if (level < cfg.decay_level) begin
          event_hit      = 1'b1;
          found_hold_nxt = 1'b1;
          restart        = 1'b1;
        end else if (decay_cnt_nxt > iocd_pkg::DECAY_CNT_W'(cfg.decay_limit)) begin
          restart = 1'b1;
        end
      end
    end
    if (restart) begin
      prev_level_nxt = '0;
      onset_seen_nxt = 1'b0;
      clip_conf_nxt  = 1'b0;
      run_cnt_nxt    = '0;
      decay_cnt_nxt  = '0;
    end
  end

  // Stage code after the word.
  always_comb begin
    if (found_hold_nxt)     stage = iocd_pkg::STAGE_HOLD;
    else if (clip_conf_nxt) stage = iocd_pkg::STAGE_DECAY;
    else if (onset_seen_nxt) stage = iocd_pkg::STAGE_CLIP;
    else                    stage = iocd_pkg::STAGE_SEEK;
  end

  assign result.event_found    = event_hit;
  assign result.detector_stage = stage;

  // State advances only when the word moves into the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_level_r <= '0;
      onset_seen_r <= 1'b0;
      clip_conf_r  <= 1'b0;
      found_hold_r <= 1'b0;
      run_cnt_r    <= '0;
      decay_cnt_r  <= '0;
    end else if (advance) begin
      prev_level_r <= prev_level_nxt;
      onset_seen_r <= onset_seen_nxt;
      clip_conf_r  <= clip_conf_nxt;
      found_hold_r <= found_hold_nxt;
      run_cnt_r    <= run_cnt_nxt;
      decay_cnt_r  <= decay_cnt_nxt;
    end
  end

endmodule

### rtl/impulse_onset_clip_decay_detector_unit.sv
// Top level of the impulse onset / clip / decay detector.
// Depends on iocd_pkg, iocd_cfg_regs and iocd_core.
//
// Usage:
// - Input channel in_valid / in_ready / in_data carries one microphone word
//   and a buffer start flag. Result channel out_valid / out_ready / out_data
//   carries one result per word: the event pulse and the detector stage.
// - Configuration port: cfg_we writes cfg_wdata into register cfg_index
//   (0 onset jump, 1 clip level, 2 min clip run, 3 max clip run,
//   4 decay level, 5 decay limit) at the clock edge. Write only while idle.
// - Path: an accepted word waits in the input register and moves into the
//   result register once that is free or being emptied, raising out_valid.
// - Throughput: one word per cycle while out_ready is high; the update is
//   a single compare-and-count step between the input and result registers.
// - Stall: while out_ready is low the result holds, the input register still
//   fills, and in_ready drops only when both registers are occupied.
// - Reset: rst_n low at a clock edge empties both registers, clears the
//   detector state and loads the default thresholds.
module impulse_onset_clip_decay_detector_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  iocd_pkg::in_item_t               in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output iocd_pkg::out_item_t              out_data,
  input  logic                             cfg_we,
  input  logic [iocd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [iocd_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  logic                 in_v_r;
  iocd_pkg::in_item_t   in_item_r;
  logic                 out_v_r;
  iocd_pkg::out_item_t  out_item_r;
  logic                 advance;
  iocd_pkg::cfg_t       cfg;
  iocd_pkg::out_item_t  result;

  // A word moves on when the result register is free or being emptied.
  assign advance  = in_v_r && (!out_v_r || out_ready);
  assign in_ready = !in_v_r || advance;

  iocd_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  iocd_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .item    (in_item_r),
    .cfg     (cfg),
    .result  (result)
  );

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ready) begin
      in_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_item_r <= in_data;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance) begin
      out_v_r <= 1'b1;
    end else if (out_ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item_r <= result;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_item_r;

endmodule
